### rtl/assert_macros.svh
// Assertion macros for the RTL top file, the one that carries checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational implication checked at every clock, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fpp_pkg.sv
// Shared types and constants of the framed packet parser.
// No dependencies; used by the controller, datapath, top and testbench through scoped names.
package fpp_pkg;

    // result kinds
    localparam logic [2:0] EV_BYTE   = 3'd0;
    localparam logic [2:0] EV_GAP    = 3'd1;
    localparam logic [2:0] EV_LONG   = 3'd2;
    localparam logic [2:0] EV_CHECK  = 3'd3;
    localparam logic [2:0] EV_FOOTER = 3'd4;

    // register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE    = 2'd2;

    // register reset values
    localparam logic [7:0] RST_GAP_TIMEOUT = 8'd25;
    localparam logic [7:0] RST_START_BYTE  = 8'h28;
    localparam logic [7:0] RST_END_BYTE    = 8'h29;

    localparam int unsigned OUT_TDATA_W = 88;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_ADDR   = 6'b000010,
        PH_LEN    = 6'b000100,
        PH_DATA   = 6'b001000,
        PH_CHECK  = 6'b010000,
        PH_FOOTER = 6'b100000
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_LOAD = 3'b100
    } t_ctrl_state;

    typedef struct packed {
        logic accept;   // input beat taken this cycle
        logic rd_en;    // read payload store at the emit index
        logic load;     // move read data into the output register
    } t_cmd;

    typedef struct packed {
        logic good_frame;  // presented beat is a matching footer
        logic out_free;    // output register can take a beat
        logic last_byte;   // emit index is the final payload byte
    } t_status;

endpackage

### rtl/fpp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/fpp_ctrl.sv
// Controller: input handshake and payload burst sequencing.
// Depends on fpp_pkg.
module fpp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  fpp_pkg::t_status i_status,
    output fpp_pkg::t_cmd    o_cmd
);

    fpp_pkg::t_ctrl_state r_state;
    fpp_pkg::t_ctrl_state n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.rd_en  = 1'b0;
        o_cmd.load   = 1'b0;
        case (r_state)
            fpp_pkg::ST_IDLE: begin
                o_in_ready   = i_status.out_free;
                o_cmd.accept = i_in_valid && i_status.out_free;
                if (o_cmd.accept && i_status.good_frame) begin
                    n_state = fpp_pkg::ST_READ;
                end
            end
            fpp_pkg::ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = fpp_pkg::ST_LOAD;
            end
            fpp_pkg::ST_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.last_byte ? fpp_pkg::ST_IDLE : fpp_pkg::ST_READ;
                end
            end
            default: begin
                n_state = fpp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/fpp_datapath.sv
// Datapath: config registers, frame parse state, counters, payload store
// and output register. Depends on fpp_pkg and fpp_ram.
module fpp_datapath #(
    parameter int unsigned MAX_PAYLOAD = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [fpp_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [7:0]                           i_cfg_wdata,
    input  logic                                 i_action,
    input  logic [7:0]                           i_byte,
    input  fpp_pkg::t_cmd                        i_cmd,
    output fpp_pkg::t_status                     o_status,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [2:0]                           o_event,
    output logic                                 o_last,
    output logic [fpp_pkg::OUT_TDATA_W-1:0]      o_tdata
);

    localparam int unsigned AW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int unsigned LW  = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned LW1 = LW + 1;
    localparam logic [LW-1:0] MAX_LEN  = LW'(MAX_PAYLOAD);
    localparam logic [7:0]    MAX_BYTE = 8'(MAX_PAYLOAD);

    // config
    logic [7:0] r_gap_timeout;
    logic [7:0] r_start_byte;
    logic [7:0] r_end_byte;

    // parse state
    fpp_pkg::t_phase r_phase, n_phase, w_eff_phase;
    logic [7:0]    r_addr, n_addr;
    logic [LW-1:0] r_exp_len, n_exp_len;
    logic [LW-1:0] r_rx_len, n_rx_len;
    logic [7:0]    r_chk, n_chk;
    logic [7:0]    r_idle, n_idle;
    logic [31:0]   r_good, r_bad;
    logic [LW-1:0] r_rd_idx;

    logic       w_err;
    logic [2:0] w_ev;
    logic       w_good;
    logic       w_we;
    logic [7:0] w_rdata;

    // output register
    logic        r_out_valid;
    logic [2:0]  r_event;
    logic        r_last;
    logic [7:0]  r_o_addr;
    logic [7:0]  r_o_byte;
    logic [4:0]  r_o_idx;
    logic [31:0] r_o_succ;
    logic [31:0] r_o_err;

    always_comb begin
        n_phase     = r_phase;
        n_addr      = r_addr;
        n_exp_len   = r_exp_len;
        n_rx_len    = r_rx_len;
        n_chk       = r_chk;
        n_idle      = r_idle;
        w_eff_phase = r_phase;
        w_err       = 1'b0;
        w_ev        = fpp_pkg::EV_GAP;
        w_good      = 1'b0;
        w_we        = 1'b0;
        if (i_action) begin
            if (r_idle != 8'hFF) begin
                n_idle = r_idle + 8'd1;
            end
        end else begin
            n_idle = 8'd0;
            if (r_phase != fpp_pkg::PH_HEADER && r_idle > r_gap_timeout) begin
                w_err       = 1'b1;
                w_ev        = fpp_pkg::EV_GAP;
                w_eff_phase = fpp_pkg::PH_HEADER;
                n_phase     = fpp_pkg::PH_HEADER;
            end
            case (w_eff_phase)
                fpp_pkg::PH_ADDR: begin
                    n_addr  = i_byte;
                    n_chk   = 8'd0;
                    n_phase = fpp_pkg::PH_LEN;
                end
                fpp_pkg::PH_LEN: begin
                    if (i_byte > MAX_BYTE) begin
                        w_err   = 1'b1;
                        w_ev    = fpp_pkg::EV_LONG;
                        n_phase = fpp_pkg::PH_HEADER;
                    end else begin
                        n_exp_len = LW'(i_byte);
                        n_chk     = r_chk ^ i_byte;
                        n_phase   = fpp_pkg::PH_DATA;
                    end
                end
                fpp_pkg::PH_DATA: begin
                    if (r_rx_len < MAX_LEN) begin
                        w_we     = 1'b1;
                        n_rx_len = r_rx_len + LW'(1);
                    end
                    n_chk = r_chk ^ i_byte;
                    if (n_rx_len >= r_exp_len || n_rx_len >= MAX_LEN) begin
                        n_phase = fpp_pkg::PH_CHECK;
                    end
                end
                fpp_pkg::PH_CHECK: begin
                    if (i_byte != r_chk) begin
                        w_err   = 1'b1;
                        w_ev    = fpp_pkg::EV_CHECK;
                        n_phase = fpp_pkg::PH_HEADER;
                    end else begin
                        n_phase = fpp_pkg::PH_FOOTER;
                    end
                end
                fpp_pkg::PH_FOOTER: begin
                    if (i_byte != r_end_byte) begin
                        w_err = 1'b1;
                        w_ev  = fpp_pkg::EV_FOOTER;
                    end else begin
                        w_good = 1'b1;
                    end
                    n_phase = fpp_pkg::PH_HEADER;
                end
                default: begin
                    n_phase  = (i_byte == r_start_byte) ? fpp_pkg::PH_ADDR
                                                        : fpp_pkg::PH_HEADER;
                    n_rx_len = '0;
                    n_chk    = 8'd0;
                end
            endcase
        end
    end

    // config writes; unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_timeout <= fpp_pkg::RST_GAP_TIMEOUT;
            r_start_byte  <= fpp_pkg::RST_START_BYTE;
            r_end_byte    <= fpp_pkg::RST_END_BYTE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fpp_pkg::CFG_GAP_TIMEOUT: r_gap_timeout <= i_cfg_wdata;
                fpp_pkg::CFG_START_BYTE:  r_start_byte  <= i_cfg_wdata;
                fpp_pkg::CFG_END_BYTE:    r_end_byte    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= fpp_pkg::PH_HEADER;
            r_addr      <= 8'd0;
            r_exp_len   <= '0;
            r_rx_len    <= '0;
            r_chk       <= 8'd0;
            r_idle      <= 8'd0;
            r_good      <= 32'd0;
            r_bad       <= 32'd0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_phase   <= n_phase;
                r_addr    <= n_addr;
                r_exp_len <= n_exp_len;
                r_rx_len  <= n_rx_len;
                r_chk     <= n_chk;
                r_idle    <= n_idle;
                if (w_err) begin
                    r_bad <= r_bad + 32'd1;
                end
                if (w_good) begin
                    r_good   <= r_good + 32'd1;
                    r_rd_idx <= '0;
                end
            end else if (i_cmd.load) begin
                r_rd_idx <= r_rd_idx + LW'(1);
            end
            if (i_cmd.accept && w_err) begin
                r_out_valid <= 1'b1;
            end else if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output beat payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_err) begin
            r_event  <= w_ev;
            r_last   <= 1'b1;
            r_o_addr <= r_addr;
            r_o_byte <= 8'd0;
            r_o_idx  <= 5'd0;
            r_o_succ <= r_good;
            r_o_err  <= r_bad + 32'd1;
        end else if (i_cmd.load) begin
            r_event  <= fpp_pkg::EV_BYTE;
            r_last   <= o_status.last_byte;
            r_o_addr <= r_addr;
            r_o_byte <= w_rdata;
            r_o_idx  <= 5'(r_rd_idx);
            r_o_succ <= r_good;
            r_o_err  <= r_bad;
        end
    end

    fpp_ram #(
        .WIDTH(8),
        .DEPTH(MAX_PAYLOAD),
        .AW   (AW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.accept && w_we),
        .i_waddr(r_rx_len[AW-1:0]),
        .i_wdata(i_byte),
        .i_re   (i_cmd.rd_en),
        .i_raddr(r_rd_idx[AW-1:0]),
        .o_rdata(w_rdata)
    );

    assign o_status.good_frame = w_good;
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.last_byte  = (LW1'(r_rd_idx) + LW1'(1)) == LW1'(r_rx_len);

    assign o_out_valid = r_out_valid;
    assign o_event     = r_event;
    assign o_last      = r_last;
    assign o_tdata     = {3'd0, r_o_err, r_o_succ, r_o_idx, r_o_byte, r_o_addr};

endmodule

### rtl/framed_packet_parser_xor_check.sv
// An error beat is loaded into the output register when its input beat is taken.
// A good footer starts a payload burst: for each byte, READ does a registered read
// of the payload RAM, then LOAD moves it to the output register when that is free.
// Input is held off for the burst. Other beats: 1/cycle while the output is free.
// Reset: synchronous active low; clears parse state, counters, output valid and
// restores config defaults. Payload RAM is not cleared (read only after written).
`include "assert_macros.svh"

module framed_packet_parser_xor_check #(
    parameter int unsigned MAX_PAYLOAD = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [fpp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [7:0]                        i_cfg_wdata,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
    input  logic                              s_axis_tuser,  // [0] action (1 = ms tick)
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] address, [15:8] payload_byte, [20:16] payload_index,
    // [52:21] success_count, [84:53] error_count, [87:85] zero
    output logic [fpp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [2:0]                        m_axis_tuser,  // [2:0] event_res
    output logic                              m_axis_tlast   // last
);

    fpp_pkg::t_cmd    w_cmd;
    fpp_pkg::t_status w_status;

    // handshake and burst sequencing
    fpp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    // parse state, counters, payload store, output register
    fpp_datapath #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_action   (s_axis_tuser),
        .i_byte     (s_axis_tdata),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_out_ready(m_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .o_event    (m_axis_tuser),
        .o_last     (m_axis_tlast),
        .o_tdata    (m_axis_tdata)
    );

    // ready only when the output slot can absorb a beat
    `ASSERT_IMPL(a_ready_needs_slot, i_clk, i_rst_n, s_axis_tready, (!m_axis_tvalid || m_axis_tready), "input ready while output slot is full")
    // a good footer blocks input for the burst
    `ASSERT_NEXT(a_burst_blocks_in, i_clk, i_rst_n, (w_cmd.accept && w_status.good_frame), !s_axis_tready, "input ready right after good footer")
    // error beats always carry last
    `ASSERT_IMPL(a_err_last, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser != fpp_pkg::EV_BYTE), m_axis_tlast, "error beat without last")
    // no burst read while an input beat is taken
    `ASSERT_IMPL(a_cmd_excl, i_clk, i_rst_n, w_cmd.accept, (!w_cmd.rd_en && !w_cmd.load), "accept overlaps burst command")

endmodule

### verif/tb.sv
// Testbench for framed_packet_parser_xor_check: drives byte/tick beats, predicts result beats.
// Depends on rtl/fpp_pkg.sv and the parser RTL; self-checking, no files or arguments.
`timescale 1ns / 100ps

module tb;

    localparam int FRAME_MAX     = 32;      // payload store depth of the DUT
    localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
    localparam int SETTLE_CYCLES = 6;       // idle wait after the last predicted beat
    localparam int RANDOM_ITEMS  = 100;
    localparam int CYCLE_LIMIT   = 400000;

    // index with no register behind it; writes must be dropped
    localparam logic [fpp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // tuser codes on the input side
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_CHECK,
        FRAME_BAD_FOOTER,
        FRAME_STALLED
    } t_frame_kind;

    // one result beat as the parser should emit it
    typedef struct {
        logic [2:0]  ev;
        logic [7:0]  addr;
        logic [7:0]  data;
        logic [4:0]  idx;
        logic        last;
        logic [31:0] good;
        logic [31:0] bad;
    } t_beat;

    // ------------------------------------------------------------------
    // DUT signals; everything the TB drives starts at a known value
    // ------------------------------------------------------------------
    logic                              i_clk;
    logic                              i_rst_n       = 1'b0;
    logic                              i_cfg_we      = 1'b0;
    logic [fpp_pkg::CFG_IDX_W-1:0]     i_cfg_idx     = fpp_pkg::CFG_GAP_TIMEOUT;
    logic [7:0]                        i_cfg_wdata   = 8'h00;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [7:0]                        s_axis_tdata  = 8'h00;  // [7:0] data_byte
    logic                              s_axis_tuser  = 1'b0;   // [0] action (1 = ms tick)
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    // [7:0] address, [15:8] payload_byte, [20:16] payload_index,
    // [52:21] success_count, [84:53] error_count, [87:85] zero
    logic [fpp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
    logic [2:0]                        m_axis_tuser;           // [2:0] event_res
    logic                              m_axis_tlast;

    framed_packet_parser_xor_check #(
        .MAX_PAYLOAD (FRAME_MAX)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Parser prediction: own copy of registers and frame state
    // ------------------------------------------------------------------
    logic [7:0]       gap_limit;
    logic [7:0]       hdr_byte;
    logic [7:0]       ftr_byte;

    fpp_pkg::t_phase  ph;
    logic [7:0]       frame_addr;
    logic [5:0]       frame_len;
    logic [5:0]       bytes_in;
    logic [7:0]       xor_acc;
    logic [7:0]       frame_bytes [FRAME_MAX];
    logic [7:0]       quiet_ms;
    logic [31:0]      good_total;
    logic [31:0]      bad_total;

    t_beat       pending_beats[$];
    int          items_sent = 0;
    int          mismatches = 0;

    function automatic void reset_parser_model();
        gap_limit  = fpp_pkg::RST_GAP_TIMEOUT;
        hdr_byte   = fpp_pkg::RST_START_BYTE;
        ftr_byte   = fpp_pkg::RST_END_BYTE;
        ph         = fpp_pkg::PH_HEADER;
        frame_addr = 8'h00;
        frame_len  = '0;
        bytes_in   = '0;
        xor_acc    = 8'h00;
        quiet_ms   = 8'h00;
        good_total = '0;
        bad_total  = '0;
    endfunction

    function automatic void queue_beat(logic [2:0] ev, logic [7:0] data, logic [4:0] idx,
                                       logic last);
        t_beat b;
        b.ev   = ev;
        b.addr = frame_addr;
        b.data = data;
        b.idx  = idx;
        b.last = last;
        b.good = good_total;
        b.bad  = bad_total;
        pending_beats.push_back(b);
    endfunction

    // every error: one beat, counted, parser back to hunting for a header
    function automatic void frame_error(logic [2:0] ev);
        bad_total = bad_total + 32'd1;
        ph        = fpp_pkg::PH_HEADER;
        queue_beat(ev, 8'h00, 5'd0, 1'b1);
    endfunction

    function automatic void parse_item(logic act, logic [7:0] b);
        if (act == ACT_TICK) begin
            if (quiet_ms != 8'hFF) quiet_ms = quiet_ms + 8'd1;
            return;
        end
        // gap judged on the arriving byte; the byte then falls through as a header
        if (ph != fpp_pkg::PH_HEADER && quiet_ms > gap_limit) frame_error(fpp_pkg::EV_GAP);
        quiet_ms = 8'h00;

        case (ph)
            fpp_pkg::PH_ADDR: begin
                frame_addr = b;
                xor_acc    = 8'h00;
                ph         = fpp_pkg::PH_LEN;
            end
            fpp_pkg::PH_LEN: begin
                if (b > FRAME_MAX) begin
                    frame_error(fpp_pkg::EV_LONG);
                end else begin
                    frame_len = b[5:0];
                    xor_acc   = xor_acc ^ b;
                    ph        = fpp_pkg::PH_DATA;
                end
            end
            fpp_pkg::PH_DATA: begin
                if (bytes_in < FRAME_MAX) begin
                    frame_bytes[bytes_in[4:0]] = b;
                    bytes_in = bytes_in + 6'd1;
                end
                xor_acc = xor_acc ^ b;
                // length zero still consumes one payload byte
                if (bytes_in >= frame_len || bytes_in >= FRAME_MAX) ph = fpp_pkg::PH_CHECK;
            end
            fpp_pkg::PH_CHECK: begin
                if (b != xor_acc) frame_error(fpp_pkg::EV_CHECK);
                else ph = fpp_pkg::PH_FOOTER;
            end
            fpp_pkg::PH_FOOTER: begin
                if (b != ftr_byte) begin
                    frame_error(fpp_pkg::EV_FOOTER);
                end else begin
                    good_total = good_total + 32'd1;
                    for (int i = 0; i < bytes_in; i++)
                        queue_beat(fpp_pkg::EV_BYTE, frame_bytes[i], i[4:0],
                                   (i + 1 == bytes_in));
                end
                ph = fpp_pkg::PH_HEADER;
            end
            default: begin
                if (b == hdr_byte) ph = fpp_pkg::PH_ADDR;
                else ph = fpp_pkg::PH_HEADER;
                bytes_in = '0;
                xor_acc  = 8'h00;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready pattern, long hold-off, and beat comparison
    // ------------------------------------------------------------------
    logic tx_gaps_on = 1'b1;
    logic rx_gaps_on = 1'b1;
    logic hold_req   = 1'b0;    // toggled by a test to start a hold-off
    logic hold_ack   = 1'b0;
    int   hold_left  = 0;

    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack      <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(rx_gaps_on && $urandom_range(99) < 26);
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    // values sampled at the edge are the pre-edge ones: no ordering hazard
    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with none pending: ev %0d data 0x%0h", $time,
                             m_axis_tuser, m_axis_tdata);
            end else begin
                want = pending_beats.pop_front();
                check_field("event",   32'(want.ev),   32'(m_axis_tuser));
                check_field("address", 32'(want.addr), 32'(m_axis_tdata[7:0]));
                check_field("payload", 32'(want.data), 32'(m_axis_tdata[15:8]));
                check_field("index",   32'(want.idx),  32'(m_axis_tdata[20:16]));
                check_field("last",    32'(want.last), 32'(m_axis_tlast));
                check_field("good",    want.good,      m_axis_tdata[52:21]);
                check_field("bad",     want.bad,       m_axis_tdata[84:53]);
            end
        end
    end

    // hard stop if the run hangs
    int unsigned cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side. Every task is entered just after a rising edge.
    // ------------------------------------------------------------------
    task automatic send_item(input logic act, input logic [7:0] b);
        while (tx_gaps_on && $urandom_range(99) < 26) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        parse_item(act, b);
        items_sent++;
    endtask

    // tick data is ignored by the DUT; random bits on it anyway
    task automatic send_tick();
        send_item(ACT_TICK, 8'($urandom));
    endtask

    // stop offering and wait for every predicted beat, plus a few idle cycles
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only called with the parser drained
    task automatic write_reg(input logic [fpp_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            fpp_pkg::CFG_GAP_TIMEOUT: gap_limit = v;
            fpp_pkg::CFG_START_BYTE:  hdr_byte  = v;
            fpp_pkg::CFG_END_BYTE:    ftr_byte  = v;
            default: ;
        endcase
    endtask

    // Whole frame with random payload. A stalled frame is cut after a random
    // byte and followed by just enough ticks to trip the gap timeout.
    task automatic send_frame(input logic [7:0] addr, input int len, input t_frame_kind kind);
        logic [7:0] seq[$];
        logic [7:0] sum;
        logic [7:0] pick;
        int         cut;
        sum = len[7:0];
        seq.push_back(hdr_byte);
        seq.push_back(addr);
        seq.push_back(len[7:0]);
        for (int i = 0; i < ((len == 0) ? 1 : len); i++) begin
            pick = 8'($urandom);
            sum  = sum ^ pick;
            seq.push_back(pick);
        end
        if (kind == FRAME_BAD_CHECK) sum = sum ^ (8'h01 << $urandom_range(7));
        seq.push_back(sum);
        pick = 8'($urandom_range(1, 255));
        seq.push_back((kind == FRAME_BAD_FOOTER) ? (ftr_byte ^ pick) : ftr_byte);

        cut = seq.size();
        if (kind == FRAME_STALLED && gap_limit != 8'hFF) cut = $urandom_range(1, seq.size() - 1);
        for (int i = 0; i < cut; i++) begin
            send_item(ACT_BYTE, seq[i]);
            // short idle within the timeout now and then
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(0, (gap_limit < 2) ? gap_limit : 2)) send_tick();
        end
        if (cut < seq.size()) repeat (int'(gap_limit) + 1) send_tick();
    endtask

    // one random unit of traffic: mostly clean frames, some broken, some noise
    task automatic send_random_unit();
        int r;
        int len;
        r   = $urandom_range(99);
        len = ($urandom_range(4) == 0) ? $urandom_range(7, FRAME_MAX) : $urandom_range(0, 6);
        if (r < 60) begin
            send_frame(8'($urandom), len, FRAME_GOOD);
        end else if (r < 68) begin
            send_frame(8'($urandom), len, FRAME_BAD_CHECK);
        end else if (r < 74) begin
            send_frame(8'($urandom), len, FRAME_BAD_FOOTER);
        end else if (r < 80) begin
            send_frame(8'($urandom), len, FRAME_STALLED);
        end else if (r < 86) begin
            // too long: header, address, length above the store size
            send_item(ACT_BYTE, hdr_byte);
            send_item(ACT_BYTE, 8'($urandom));
            send_item(ACT_BYTE, 8'($urandom_range(FRAME_MAX + 1, 255)));
        end else if (r < 93) begin
            repeat ($urandom_range(1, 4)) send_item(ACT_BYTE, 8'($urandom));
        end else begin
            repeat ($urandom_range(1, 4)) send_tick();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset defaults: field extremes and the length, check and footer errors
    task automatic test_directed_frames();
        // length zero takes one payload byte; address and payload at 0xFF
        send_item(ACT_BYTE, fpp_pkg::RST_START_BYTE);
        send_item(ACT_BYTE, 8'hFF);
        send_item(ACT_BYTE, 8'h00);
        send_item(ACT_BYTE, 8'hFF);
        send_item(ACT_BYTE, 8'hFF);
        send_item(ACT_BYTE, fpp_pkg::RST_END_BYTE);
        // length just over the limit, then the largest length byte
        send_item(ACT_BYTE, fpp_pkg::RST_START_BYTE);
        send_item(ACT_BYTE, 8'h00);
        send_item(ACT_BYTE, 8'(FRAME_MAX + 1));
        send_item(ACT_BYTE, fpp_pkg::RST_START_BYTE);
        send_item(ACT_BYTE, 8'h12);
        send_item(ACT_BYTE, 8'hFF);
        // stray byte while hunting, tick while hunting
        send_item(ACT_BYTE, 8'h00);
        send_tick();
        send_frame(8'h5A, 2, FRAME_BAD_CHECK);
        send_frame(8'hA5, 1, FRAME_BAD_FOOTER);
        drain_results();
    endtask

    // gap timeout edges: zero, exactly at/just over, never (255), saturated idle count
    task automatic test_gap_limits();
        write_reg(fpp_pkg::CFG_GAP_TIMEOUT, 8'd0);
        // one tick mid-frame trips it; the late byte restarts as a header
        send_item(ACT_BYTE, hdr_byte);
        send_item(ACT_BYTE, 8'h33);
        send_tick();
        send_item(ACT_BYTE, hdr_byte);
        send_item(ACT_BYTE, 8'h44);
        send_item(ACT_BYTE, 8'h01);
        send_item(ACT_BYTE, 8'h80);
        send_item(ACT_BYTE, 8'h81);
        send_item(ACT_BYTE, ftr_byte);
        drain_results();

        write_reg(fpp_pkg::CFG_GAP_TIMEOUT, 8'd3);
        // exactly at the limit: no error
        send_item(ACT_BYTE, hdr_byte);
        send_item(ACT_BYTE, 8'h0F);
        send_item(ACT_BYTE, 8'h01);
        send_item(ACT_BYTE, 8'h01);
        repeat (3) send_tick();
        send_item(ACT_BYTE, 8'h00);
        send_item(ACT_BYTE, ftr_byte);
        // one over: error
        send_item(ACT_BYTE, hdr_byte);
        send_item(ACT_BYTE, 8'hF0);
        repeat (4) send_tick();
        send_item(ACT_BYTE, 8'h00);
        drain_results();

        // 255 never times out
        write_reg(fpp_pkg::CFG_GAP_TIMEOUT, 8'd255);
        send_item(ACT_BYTE, hdr_byte);
        send_item(ACT_BYTE, 8'h77);
        repeat (20) send_tick();
        send_item(ACT_BYTE, 8'h00);
        send_item(ACT_BYTE, 8'h3C);
        send_item(ACT_BYTE, 8'h3C);
        send_item(ACT_BYTE, ftr_byte);
        drain_results();

        // saturated count of 255 still exceeds 254; a wrapped count would not
        write_reg(fpp_pkg::CFG_GAP_TIMEOUT, 8'd254);
        send_item(ACT_BYTE, hdr_byte);
        send_item(ACT_BYTE, 8'h88);
        repeat (256) send_tick();
        send_item(ACT_BYTE, 8'h05);
        drain_results();
    endtask

    // several register settings, extremes included; unused index must not disturb
    task automatic test_register_sweep();
        logic [7:0] g;
        logic [7:0] s;
        logic [7:0] e;
        for (int k = 0; k < 4; k++) begin
            case (k)
                0: begin g = 8'd0;   s = 8'h00; e = 8'hFF; end
                1: begin g = 8'd255; s = 8'hFF; e = 8'h00; end
                2: begin g = 8'd6;   s = 8'h7E; e = 8'h7E; end   // header equals footer
                default: begin
                    g = 8'($urandom_range(2, 20));
                    s = 8'($urandom);
                    e = 8'($urandom);
                end
            endcase
            write_reg(fpp_pkg::CFG_GAP_TIMEOUT, g);
            write_reg(fpp_pkg::CFG_START_BYTE, s);
            write_reg(fpp_pkg::CFG_END_BYTE, e);
            write_reg(CFG_UNUSED, 8'($urandom));
            repeat (2) send_random_unit();
            drain_results();
        end
    endtask

    // receiver stalls long while frames keep coming: output fills,
    // input stalls, then everything has to drain in order
    task automatic test_backpressure();
        hold_req <= ~hold_req;
        send_frame(8'($urandom), FRAME_MAX, FRAME_GOOD);
        send_item(ACT_BYTE, hdr_byte);
        send_item(ACT_BYTE, 8'hFF);
        send_item(ACT_BYTE, 8'($urandom_range(FRAME_MAX + 1, 255)));
        send_frame(8'h00, 8, FRAME_BAD_CHECK);
        send_frame(8'h01, FRAME_MAX, FRAME_GOOD);
        drain_results();
    endtask

    // bulk random traffic with a stretch of back-to-back beats in the middle
    task automatic test_random_traffic();
        int base;
        write_reg(fpp_pkg::CFG_GAP_TIMEOUT, 8'($urandom_range(3, 12)));
        write_reg(fpp_pkg::CFG_START_BYTE, 8'($urandom));
        write_reg(fpp_pkg::CFG_END_BYTE, 8'($urandom));
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            tx_gaps_on = !((items_sent - base >= 20) && (items_sent - base < 80));
            rx_gaps_on <= tx_gaps_on;
            send_random_unit();
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on <= 1'b1;
    endtask

    initial begin
        reset_parser_model();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_frames();
        test_gap_limits();
        test_register_sweep();
        test_backpressure();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_beats.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/fpp_pkg.sv
rtl/fpp_ram.sv
rtl/fpp_ctrl.sv
rtl/fpp_datapath.sv
rtl/framed_packet_parser_xor_check.sv
verif/tb.sv
